### src/pac_pkg.sv
`timescale 1ns / 1ps
package pac_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int DELTA_BITS = 16;
  localparam int OUT_BITS   = 23;
  localparam int TIME_BITS  = 64;
  localparam int ACT_BITS   = 2;
  localparam int CIDX_BITS  = 8;
  localparam int CDATA_BITS = 24;
  localparam int BASE_BITS  = 23;
  localparam int ACCEL_BITS = 24;
  localparam int KNEE_BITS  = 24;
  localparam int IDLE_BITS  = 20;
  localparam int SUM_BITS   = 24;
  localparam int GAIN_BITS  = 23;
  localparam int REM_BITS   = FRAC_BITS + 1;

  localparam int SQ_BITS    = 2 * SUM_BITS;
  localparam int RAD_BITS   = 64;
  localparam int ROOT_BITS  = RAD_BITS / 2;
  localparam int SREM_BITS  = ROOT_BITS + 2;
  localparam int NUM_BITS   = ROOT_BITS + 10 + (FRAC_BITS - 8);
  localparam int DEN_BITS   = NUM_BITS + 1;
  localparam int RESP_BITS  = FRAC_BITS + 1;
  localparam int CNT_BITS   = 6;

  localparam int SQRT_STEPS = ROOT_BITS;
  localparam int DIV_STEPS  = NUM_BITS;
  localparam int RESP_STEPS = FRAC_BITS;
  localparam int MS_PER_S   = 1000;

  localparam logic [GAIN_BITS-1:0] ONE_Q    = GAIN_BITS'(1) << FRAC_BITS;
  localparam logic [GAIN_BITS-1:0] GAIN_MAX = GAIN_BITS'(64) << FRAC_BITS;

  localparam logic [BASE_BITS-1:0]  BASE_RST  = BASE_BITS'(65536);
  localparam logic [KNEE_BITS-1:0]  KNEE_RST  = KNEE_BITS'(6554);
  localparam logic [IDLE_BITS-1:0]  IDLE_RST  = IDLE_BITS'(333333);

  typedef enum logic [ACT_BITS-1:0] {
    ACT_X      = 2'd0,
    ACT_Y      = 2'd1,
    ACT_BUTTON = 2'd2,
    ACT_OTHER  = 2'd3
  } action_t;

  typedef enum logic [CIDX_BITS-1:0] {
    REG_BASE  = 8'd0,
    REG_ACCEL = 8'd1,
    REG_KNEE  = 8'd2,
    REG_IDLE  = 8'd3
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EVAL, ST_SQ_X, ST_SQ_Y, ST_SQRT, ST_SPEED, ST_DIV,
    ST_RESP_INIT, ST_RESP, ST_PROD, ST_FACTOR, ST_GMUL, ST_GCLAMP,
    ST_OPEN, ST_ACCUM, ST_SCALE
  } state_t;

endpackage

### src/pac_in_if.sv
`timescale 1ns / 1ps
interface pac_in_if import pac_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic [ACT_BITS-1:0]          action;
  logic signed [DELTA_BITS-1:0] event_value;
  logic [TIME_BITS-1:0]         timestamp_us;

  modport source (output valid, action, event_value, timestamp_us, input ready);
  modport sink (input valid, action, event_value, timestamp_us, output ready);
endinterface

### src/pac_out_if.sv
`timescale 1ns / 1ps
interface pac_out_if import pac_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] out_value;

  modport source (output valid, out_value, input ready);
  modport sink (input valid, out_value, output ready);
endinterface

### src/pac_cfg_if.sv
`timescale 1ns / 1ps
interface pac_cfg_if import pac_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CIDX_BITS-1:0]  index;
  logic [CDATA_BITS-1:0] value;

  modport source (output valid, index, value, input ready);
  modport sink (input valid, index, value, output ready);
endinterface

### src/pointer_accel_curve.sv
`timescale 1ns / 1ps
// Channel   Dir  Payload                                  Transfer
// in_ch     in   action, event_value, timestamp_us        valid & ready
// out_ch    out  out_value                                valid & ready
// cfg       in   index, value                             valid & ready (ready always high)
//
// One event at a time. A new report with acceleration runs through the
// 2-bit-per-cycle square root (32 steps), the bit-serial speed division
// (50 steps) and the response division (16 steps); buttons, passthrough
// values and motion without a new report skip them.
// Reset is synchronous and restores the register defaults and motion state.
// A waiting result sits in the output register; the next event is taken
// meanwhile and holds before its result until the output is free.
module pointer_accel_curve import pac_pkg::*; (
  input logic    clk,
  input logic    rst,
  pac_in_if.sink     in_ch,
  pac_out_if.source  out_ch,
  pac_cfg_if.sink    cfg
);

  state_t state, state_next;

  logic [BASE_BITS-1:0]         base_gain;
  logic signed [ACCEL_BITS-1:0] accel_amount;
  logic [KNEE_BITS-1:0]         velocity_knee;
  logic [IDLE_BITS-1:0]         idle_limit_us;

  logic                         button_held;
  logic                         report_open;
  logic [TIME_BITS-1:0]         report_time;
  logic signed [SUM_BITS-1:0]   sum_dx;
  logic signed [SUM_BITS-1:0]   sum_dy;
  logic [GAIN_BITS-1:0]         current_gain;
  logic signed [REM_BITS-1:0]   x_rem;
  logic signed [REM_BITS-1:0]   y_rem;

  logic [ACT_BITS-1:0]          act;
  logic signed [DELTA_BITS-1:0] raw;
  logic [TIME_BITS-1:0]         tstamp;

  logic [IDLE_BITS-1:0]         dt;
  logic [SQ_BITS-1:0]           sq;
  logic [RAD_BITS-1:0]          rad;
  logic [ROOT_BITS-1:0]         root;
  logic [SREM_BITS-1:0]         srem;
  logic [NUM_BITS-1:0]          num;
  logic [IDLE_BITS-1:0]         drem;
  logic [NUM_BITS-1:0]          speed;
  logic [DEN_BITS-1:0]          den;
  logic [DEN_BITS-1:0]          rrem;
  logic [RESP_BITS-1:0]         resp;
  logic signed [41:0]           prod;
  logic [ACCEL_BITS-1:0]        factor;
  logic [46:0]                  gprod;
  logic signed [40:0]           total;
  logic [CNT_BITS-1:0]          cnt;
  logic signed [OUT_BITS-1:0]   res;
  logic                         res_ready;
  logic                         out_valid;
  logic signed [OUT_BITS-1:0]   out_value;

  logic                         in_fire;
  logic                         bypass;
  logic                         need_open;
  logic [TIME_BITS-1:0]         tdiff;
  logic signed [OUT_BITS-1:0]   raw_ext;

  logic [SREM_BITS+1:0]         s_try;
  logic [SREM_BITS+1:0]         s_trial;
  logic [IDLE_BITS:0]           d_try;
  logic [DEN_BITS:0]            r_try;
  logic signed [SUM_BITS:0]     sum_sel;
  logic signed [SUM_BITS-1:0]   sum_sat;
  logic signed [REM_BITS-1:0]   rem_sel;
  logic signed [47:0]           px;
  logic signed [47:0]           py;
  logic signed [26:0]           fac_full;
  logic [30:0]                  gshift;
  logic signed [24:0]           whole_hi;
  logic signed [24:0]           whole;
  logic                         frac_nz;
  logic signed [REM_BITS-1:0]   rem_new;
  logic signed [OUT_BITS-1:0]   whole_sat;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign bypass    = button_held || (base_gain == BASE_BITS'(ONE_Q) && accel_amount == '0);
  assign need_open = !report_open || tstamp != report_time;
  assign tdiff     = tstamp - report_time;
  assign raw_ext   = {{(OUT_BITS-DELTA_BITS){raw[DELTA_BITS-1]}}, raw};

  assign s_try   = {srem, rad[RAD_BITS-1 -: 2]};
  assign s_trial = {2'b00, root, 2'b01};
  assign d_try   = {drem, num[NUM_BITS-1]};
  assign r_try   = {rrem, 1'b0};

  assign rem_sel = (act == ACT_X) ? x_rem : y_rem;
  assign sum_sel = ((act == ACT_X) ? SUM_BITS'(sum_dx) : SUM_BITS'(sum_dy)) + raw;
  assign sum_sat = (sum_sel > (SUM_BITS+1)'((1 <<< (SUM_BITS-1)) - 1)) ?
                     {1'b0, {(SUM_BITS-1){1'b1}}} :
                   (sum_sel < -(SUM_BITS+1)'(1 <<< (SUM_BITS-1))) ?
                     {1'b1, {(SUM_BITS-1){1'b0}}} : sum_sel[SUM_BITS-1:0];

  assign px       = sum_dx * sum_dx;
  assign py       = sum_dy * sum_dy;
  assign fac_full = 27'(signed'({1'b0, ONE_Q})) + 27'(prod >>> FRAC_BITS);
  assign gshift   = 31'(gprod >> FRAC_BITS);

  assign whole_hi  = 25'(total >>> FRAC_BITS);
  assign frac_nz   = total[FRAC_BITS-1:0] != '0;
  assign whole     = (total[40] && frac_nz) ? whole_hi + 25'sd1 : whole_hi;
  assign rem_new   = (total[40] && frac_nz) ? {1'b1, total[FRAC_BITS-1:0]}
                                            : {1'b0, total[FRAC_BITS-1:0]};
  assign whole_sat = (whole > 25'sd4194303) ? 23'sh3FFFFF :
                     (whole < -25'sd4194304) ? 23'sh400000 : whole[OUT_BITS-1:0];

  assign cfg.ready        = 1'b1;
  assign out_ch.valid     = out_valid;
  assign out_ch.out_value = out_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ch.ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ch.ready = !res_ready;
        if (in_fire) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (act == ACT_BUTTON || act == ACT_OTHER || bypass) begin
          state_next = ST_IDLE;
        end else if (need_open) begin
          if (report_open && tstamp > report_time && tdiff <= TIME_BITS'(idle_limit_us)
              && accel_amount != '0) state_next = ST_SQ_X;
          else state_next = ST_OPEN;
        end else begin
          state_next = ST_ACCUM;
        end
      end
      ST_SQ_X:  state_next = ST_SQ_Y;
      ST_SQ_Y:  state_next = ST_SQRT;
      ST_SQRT:  if (cnt == '0) state_next = ST_SPEED;
      ST_SPEED: state_next = ST_DIV;
      ST_DIV:   if (cnt == '0) state_next = ST_RESP_INIT;
      ST_RESP_INIT: state_next = (num == '0) ? ST_OPEN : ST_RESP;
      ST_RESP:  if (cnt == '0) state_next = ST_PROD;
      ST_PROD:  state_next = ST_FACTOR;
      ST_FACTOR: state_next = (fac_full <= 27'sd0) ? ST_OPEN : ST_GMUL;
      ST_GMUL:  state_next = ST_GCLAMP;
      ST_GCLAMP: state_next = ST_OPEN;
      ST_OPEN:  state_next = ST_ACCUM;
      ST_ACCUM: begin
        if (raw == '0 || (current_gain == ONE_Q && rem_sel == '0)) state_next = ST_IDLE;
        else state_next = ST_SCALE;
      end
      ST_SCALE: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_gain     <= BASE_RST;
      accel_amount  <= '0;
      velocity_knee <= KNEE_RST;
      idle_limit_us <= IDLE_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_BASE:  base_gain     <= cfg.value[BASE_BITS-1:0];
        REG_ACCEL: accel_amount  <= signed'(cfg.value[ACCEL_BITS-1:0]);
        REG_KNEE:  velocity_knee <= cfg.value[KNEE_BITS-1:0];
        REG_IDLE:  idle_limit_us <= cfg.value[IDLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready && (!out_valid || out_ch.ready)) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
    if (res_ready && (!out_valid || out_ch.ready)) out_value <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_ready    <= 1'b0;
      button_held  <= 1'b0;
      report_open  <= 1'b0;
      report_time  <= '0;
      sum_dx       <= '0;
      sum_dy       <= '0;
      current_gain <= GAIN_BITS'(BASE_RST);
      x_rem        <= '0;
      y_rem        <= '0;
    end else begin
      if (res_ready && (!out_valid || out_ch.ready)) res_ready <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            act    <= in_ch.action;
            raw    <= in_ch.event_value;
            tstamp <= in_ch.timestamp_us;
          end
        end
        ST_EVAL: begin
          if (act == ACT_BUTTON) begin
            res       <= raw_ext;
            res_ready <= 1'b1;
            if ((raw != '0) != button_held) begin
              button_held  <= raw != '0;
              report_open  <= 1'b0;
              report_time  <= '0;
              sum_dx       <= '0;
              sum_dy       <= '0;
              current_gain <= base_gain;
              x_rem        <= '0;
              y_rem        <= '0;
            end
          end else if (act == ACT_OTHER || bypass) begin
            res       <= raw_ext;
            res_ready <= 1'b1;
          end else if (need_open) begin
            dt           <= tdiff[IDLE_BITS-1:0];
            current_gain <= base_gain;
            if (report_open && tstamp < report_time) begin
              x_rem <= '0;
              y_rem <= '0;
            end
            if (report_open && tstamp > report_time && tdiff > TIME_BITS'(idle_limit_us)) begin
              x_rem <= '0;
              y_rem <= '0;
            end
          end
        end
        ST_SQ_X: sq <= SQ_BITS'(unsigned'(px));
        ST_SQ_Y: begin
          rad  <= RAD_BITS'(sq + SQ_BITS'(unsigned'(py))) << 16;
          root <= '0;
          srem <= '0;
          cnt  <= CNT_BITS'(SQRT_STEPS - 1);
        end
        ST_SQRT: begin
          rad <= rad << 2;
          cnt <= cnt - 1'b1;
          if (s_try >= s_trial) begin
            srem <= SREM_BITS'(s_try - s_trial);
            root <= {root[ROOT_BITS-2:0], 1'b1};
          end else begin
            srem <= s_try[SREM_BITS-1:0];
            root <= {root[ROOT_BITS-2:0], 1'b0};
          end
        end
        ST_SPEED: begin
          num  <= NUM_BITS'(root * 42'(MS_PER_S)) << (FRAC_BITS - 8);
          drem <= '0;
          cnt  <= CNT_BITS'(DIV_STEPS - 1);
        end
        ST_DIV: begin
          cnt <= cnt - 1'b1;
          if (d_try >= {1'b0, dt}) begin
            drem <= IDLE_BITS'(d_try - {1'b0, dt});
            num  <= {num[NUM_BITS-2:0], 1'b1};
          end else begin
            drem <= d_try[IDLE_BITS-1:0];
            num  <= {num[NUM_BITS-2:0], 1'b0};
          end
        end
        ST_RESP_INIT: begin
          speed <= num;
          den   <= DEN_BITS'(num) + DEN_BITS'(velocity_knee);
          rrem  <= DEN_BITS'(num);
          resp  <= '0;
          cnt   <= CNT_BITS'(RESP_STEPS - 1);
        end
        ST_RESP: begin
          cnt <= cnt - 1'b1;
          if (r_try >= {1'b0, den}) begin
            rrem <= DEN_BITS'(r_try - {1'b0, den});
            resp <= {resp[RESP_BITS-2:0], 1'b1};
          end else begin
            rrem <= r_try[DEN_BITS-1:0];
            resp <= {resp[RESP_BITS-2:0], 1'b0};
          end
        end
        ST_PROD: begin
          if (DEN_BITS'(speed) == den) prod <= accel_amount * signed'({1'b0, RESP_BITS'(ONE_Q)});
          else prod <= accel_amount * signed'({1'b0, resp});
        end
        ST_FACTOR: begin
          factor <= fac_full[ACCEL_BITS-1:0];
          if (fac_full <= 27'sd0) current_gain <= '0;
        end
        ST_GMUL: gprod <= base_gain * factor;
        ST_GCLAMP: begin
          current_gain <= (gshift > 31'(GAIN_MAX)) ? GAIN_MAX : gshift[GAIN_BITS-1:0];
        end
        ST_OPEN: begin
          report_time <= tstamp;
          report_open <= 1'b1;
          sum_dx      <= '0;
          sum_dy      <= '0;
        end
        ST_ACCUM: begin
          if (act == ACT_X) sum_dx <= sum_sat;
          else sum_dy <= sum_sat;
          total <= raw * signed'({1'b0, current_gain}) + rem_sel;
          if (raw == '0) begin
            res       <= '0;
            res_ready <= 1'b1;
          end else if (current_gain == ONE_Q && rem_sel == '0) begin
            res       <= raw_ext;
            res_ready <= 1'b1;
          end
        end
        ST_SCALE: begin
          res       <= whole_sat;
          res_ready <= 1'b1;
          if (act == ACT_X) x_rem <= rem_new;
          else y_rem <= rem_new;
        end
        default: ;
      endcase
      if (state == ST_RESP_INIT && num == '0) current_gain <= base_gain;
    end
  end

  a_accept_eval: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state == ST_EVAL)
    else $error("accepted event did not start evaluation");

  a_gain_cap: assert property (@(posedge clk) disable iff (rst)
    current_gain <= GAIN_MAX)
    else $error("gain above cap");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    x_rem != {1'b1, {FRAC_BITS{1'b0}}} && y_rem != {1'b1, {FRAC_BITS{1'b0}}})
    else $error("remainder reached a whole count");

  a_held_closed: assert property (@(posedge clk) disable iff (rst)
    button_held |-> !report_open)
    else $error("report open while button held");

endmodule
